>>> src/subscription_record_validator_defines.svh
// Assertion macros shared by the record validator RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef SUBSCRIPTION_RECORD_VALIDATOR_DEFINES_SVH
`define SUBSCRIPTION_RECORD_VALIDATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset
`define SRV_ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("record validator check failed");

// Same-cycle implication
`define SRV_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("record validator check failed");

// Next-cycle implication
`define SRV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("record validator check failed");

`else

`define SRV_ASSERT_ALWAYS(label, clk, rst, prop)
`define SRV_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SRV_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/srv_pkg.sv
`default_nettype none

package srv_pkg;

  // Record layout
  localparam logic [5:0] POS_SCHEMA     = 6'd4;
  localparam logic [5:0] POS_SLOTS      = 6'd5;
  localparam logic [5:0] POS_REV        = 6'd8;
  localparam logic [5:0] HDR_LEN        = 6'd12;
  localparam logic [5:0] CRC_OFFSET     = 6'd44;
  localparam logic [5:0] POS_LAST       = 6'd47;

  localparam int unsigned SLOTS         = 4;
  localparam int unsigned ADDR_W        = 48;

  // Offsets inside one 8-byte entry
  localparam logic [2:0] ENT_FLAG       = 3'd0;
  localparam logic [2:0] ENT_PAD        = 3'd1;
  localparam logic [2:0] ENT_ADDR0      = 3'd2;
  localparam logic [2:0] ENT_ADDR_LAST  = 3'd7;

  // Expected header values; magic "HCS1", byte 0 in bits 7:0
  localparam logic [31:0] MAGIC         = 32'h3153_4348;
  localparam logic [7:0]  SCHEMA        = 8'h01;
  localparam logic [7:0]  SLOT_COUNT    = 8'h04;
  localparam logic [7:0]  FLAG_MAX      = 8'h01;

  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

  // Result payload, last declared field in the low bits
  typedef struct packed {
    logic [2:0]        pad;
    logic [ADDR_W-1:0] peer_three;
    logic [ADDR_W-1:0] peer_two;
    logic [ADDR_W-1:0] peer_one;
    logic [ADDR_W-1:0] peer_zero;
    logic [3:0]        valid_mask;
    logic [31:0]       revision;
    logic              ok;
  } srv_result_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/subscription_record_validator.sv
// Subscription record validator.
// Slave stream s_axis_* carries one record byte per transaction (tdata[7:0]).
// A record is 48 bytes; after byte 47 one verdict transaction leaves on m_axis_*.
// Bytes are taken one per cycle while s_axis_tvalid is high, except while byte 47 waits.
// Each accepted byte lands in an input register and is checked, CRC-updated
// and stored on the following cycle, unless it is byte 47 waiting as below;
// the verdict and out_valid (m_axis_tvalid) are loaded as byte 47 is processed.
// A verdict waiting in the output register does not stop bytes of the next
// record. Only byte 47 waits in the input register until the output register
// is free; while it waits s_axis_tready stays low.
// On a failed check ok is 0 and every other result field is zero.
// Reset (rst, synchronous, active high) drops both valids and restarts the
// record at byte 0; the validator also rearms itself after every verdict.
`default_nettype none

`include "subscription_record_validator_defines.svh"

module subscription_record_validator
  import srv_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] record_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [0] ok, [32:1] revision, [36:33] valid_mask, [84:37] peer_zero,
  // [132:85] peer_one, [180:133] peer_two, [228:181] peer_three, [231:229] zero
  output logic [231:0]      m_axis_tdata
);

  // Input register
  logic        in_valid;
  logic [7:0]  in_byte;

  // Record state
  logic [5:0]        pos;
  logic [31:0]       crc;
  logic [31:0]       rev;
  logic [31:0]       stored;
  logic [3:0]        flags;
  logic [ADDR_W-1:0] addr [SLOTS];
  logic              failed;

  logic [5:0]        pos_next;
  logic [31:0]       crc_next;
  logic [31:0]       rev_next;
  logic [31:0]       stored_next;
  logic [3:0]        flags_next;
  logic [ADDR_W-1:0] addr_next [SLOTS];
  logic              failed_next;

  // Output register
  logic        out_valid;
  srv_result_t out_data;
  srv_result_t result;

  logic        last;
  logic        pass;
  logic        adv;
  logic        out_free;
  logic [5:0]  rel;
  logic [1:0]  ent;
  logic [2:0]  off;
  logic [2:0]  lane;
  logic [ADDR_W-1:0] addr_full;
  logic        dup;

  assign last     = (pos >= POS_LAST);
  assign out_free = !out_valid || m_axis_tready;
  assign adv      = in_valid && (!last || out_free);
  assign s_axis_tready = !in_valid || adv;

  assign rel  = pos - HDR_LEN;
  assign ent  = rel[4:3];
  assign off  = rel[2:0];
  assign lane = off - ENT_ADDR0;

  // Byte check and state update
  always_comb begin
    pos_next    = pos + 6'd1;
    crc_next    = crc;
    rev_next    = rev;
    stored_next = stored;
    flags_next  = flags;
    addr_next   = addr;
    failed_next = failed;
    addr_full   = {in_byte, addr[ent][39:0]};
    dup         = 1'b0;

    // Same address in an earlier set entry
    for (int j = 0; j < SLOTS; j++) begin
      if ((2'(j) < ent) && flags[j] && (addr[j] == addr_full)) begin
        dup = 1'b1;
      end
    end

    if (pos < CRC_OFFSET) begin
      crc_next = crc_byte(crc, in_byte);
    end

    priority if (pos < POS_SCHEMA) begin
      if (in_byte != MAGIC[{pos[1:0], 3'b000} +: 8]) failed_next = 1'b1;
    end else if (pos == POS_SCHEMA) begin
      if (in_byte != SCHEMA) failed_next = 1'b1;
    end else if (pos == POS_SLOTS) begin
      if (in_byte != SLOT_COUNT) failed_next = 1'b1;
    end else if (pos < POS_REV) begin
      if (in_byte != 8'd0) failed_next = 1'b1;
    end else if (pos < HDR_LEN) begin
      rev_next[{pos[1:0], 3'b000} +: 8] = in_byte;
    end else if (pos < CRC_OFFSET) begin
      priority if (off == ENT_FLAG) begin
        if (in_byte > FLAG_MAX) failed_next = 1'b1;
        if (in_byte == FLAG_MAX) flags_next[ent] = 1'b1;
      end else if (off == ENT_PAD) begin
        if (in_byte != 8'd0) failed_next = 1'b1;
      end else begin
        addr_next[ent][{lane, 3'b000} +: 8] = in_byte;
        if (off == ENT_ADDR_LAST) begin
          if (!flags[ent]) begin
            if (addr_full != '0) failed_next = 1'b1;
          end else if (addr_full == '0 || addr_full == ADDR_ONES || dup) begin
            failed_next = 1'b1;
          end
        end
      end
    end else begin
      stored_next[{pos[1:0], 3'b000} +: 8] = in_byte;
    end

    // Verdict on the last byte
    pass = !failed && (pos == POS_LAST) && (rev != 32'd0) && (stored_next == ~crc);

    result            = '0;
    result.ok         = pass;
    if (pass) begin
      result.revision   = rev;
      result.valid_mask = flags;
      result.peer_zero  = addr[0];
      result.peer_one   = addr[1];
      result.peer_two   = addr[2];
      result.peer_three = addr[3];
    end
  end

  // Input, state and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      pos       <= '0;
      crc       <= CRC_INIT;
      rev       <= '0;
      stored    <= '0;
      flags     <= '0;
      failed    <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        addr[i] <= '0;
      end
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
        in_byte  <= s_axis_tdata;
      end

      if (adv && last) begin
        out_valid <= 1'b1;
        out_data  <= result;
        pos       <= '0;
        crc       <= CRC_INIT;
        rev       <= '0;
        stored    <= '0;
        flags     <= '0;
        failed    <= 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          addr[i] <= '0;
        end
      end else begin
        if (m_axis_tready) begin
          out_valid <= 1'b0;
        end
        if (adv) begin
          pos    <= pos_next;
          crc    <= crc_next;
          rev    <= rev_next;
          stored <= stored_next;
          flags  <= flags_next;
          failed <= failed_next;
          addr   <= addr_next;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Checks
  `SRV_ASSERT_ALWAYS(a_pos_range, clk, rst, pos <= POS_LAST)
  `SRV_ASSERT_NEXT(a_rearm, clk, rst, adv && last, pos == '0 && crc == CRC_INIT && !failed)
  `SRV_ASSERT_IMPL(a_fail_zero, clk, rst, out_valid && !out_data.ok, out_data[231:1] == '0)
  `SRV_ASSERT_IMPL(a_mask_peer, clk, rst, out_valid && out_data.ok, (out_data.valid_mask[0] == (out_data.peer_zero != '0)) && (out_data.valid_mask[3] == (out_data.peer_three != '0)))
  `SRV_ASSERT_IMPL(a_last_waits, clk, rst, in_valid && last && !out_free, !s_axis_tready)

endmodule

`default_nettype wire
